### src/obd_pkg.sv
// ----------------------------------------------------------------------------
// obd_pkg
// Shared types, rule codes and the mode-1 PID lookup for the value decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package obd_pkg;

	localparam int unsigned QueueDepth = 2;

	typedef logic [4:0] rule_t;
	localparam rule_t R_NONE    = 5'd0;
	localparam rule_t R_SIMPLE  = 5'd1;
	localparam rule_t R_OFF40   = 5'd2;
	localparam rule_t R_PCT     = 5'd3;
	localparam rule_t R_CTR     = 5'd4;
	localparam rule_t R_RPM     = 5'd5;
	localparam rule_t R_KPA     = 5'd6;
	localparam rule_t R_FPRESS  = 5'd7;
	localparam rule_t R_TIMING  = 5'd8;
	localparam rule_t R_MAF     = 5'd9;
	localparam rule_t R_O2V     = 5'd10;
	localparam rule_t R_RAILVAC = 5'd11;
	localparam rule_t R_RAILW10 = 5'd12;
	localparam rule_t R_EVAP    = 5'd13;
	localparam rule_t R_CAT     = 5'd14;
	localparam rule_t R_VOLT    = 5'd15;
	localparam rule_t R_EQUIV   = 5'd16;
	localparam rule_t R_U16     = 5'd17;
	localparam rule_t R_FRATE   = 5'd18;
	localparam rule_t R_INJ     = 5'd19;
	localparam rule_t R_ABSEVAP = 5'd20;
	localparam rule_t R_MPH     = 5'd21;
	localparam rule_t R_ABSLOAD = 5'd22;
	localparam rule_t R_MAXMAF  = 5'd23;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_UNKN  = 2'd1;
	localparam status_t ST_SHORT = 2'd2;

	localparam logic [7:0] MODE_CURRENT = 8'd1;

	// Classified item handed from the front to the back part
	typedef struct packed {
		rule_t       rule;
		status_t     status;
		logic [7:0]  a;
		logic [15:0] w;
		logic [7:0]  pid;
	} cls_t;

	// Mode-1 PID to scaling rule
	function automatic rule_t rule_of(input logic [7:0] pid);
		rule_t r;
		case (pid)
			8'h05, 8'h0F, 8'h46, 8'h5C: r = R_OFF40;
			8'h04, 8'h11, 8'h2F, 8'h45, 8'h47, 8'h49, 8'h2C, 8'h52, 8'h4A,
			8'h4B, 8'h4C, 8'h5A, 8'h5B, 8'h2E, 8'h4F: r = R_PCT;
			8'h06, 8'h07, 8'h08, 8'h09, 8'h2D, 8'h56, 8'h57, 8'h58: r = R_CTR;
			8'h42: r = R_VOLT;
			8'h0E: r = R_TIMING;
			8'h10: r = R_MAF;
			8'h0D: r = R_MPH;
			8'h0C: r = R_RPM;
			8'h44: r = R_EQUIV;
			8'h0B, 8'h33: r = R_KPA;
			8'h14, 8'h15, 8'h16, 8'h17: r = R_O2V;
			8'h0A: r = R_FPRESS;
			8'h1F, 8'h21, 8'h31, 8'h4D, 8'h4E: r = R_U16;
			8'h22: r = R_RAILVAC;
			8'h23, 8'h59: r = R_RAILW10;
			8'h3C, 8'h3D, 8'h3E, 8'h3F: r = R_CAT;
			8'h32, 8'h55: r = R_EVAP;
			8'h30, 8'h51: r = R_SIMPLE;
			8'h43: r = R_ABSLOAD;
			8'h50: r = R_MAXMAF;
			8'h54: r = R_ABSEVAP;
			8'h5D: r = R_INJ;
			8'h5E: r = R_FRATE;
			default: r = R_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] bytes_needed(input rule_t r);
		logic [1:0] n;
		case (r)
			R_SIMPLE, R_OFF40, R_PCT, R_CTR, R_KPA, R_FPRESS, R_TIMING,
			R_MPH, R_MAXMAF: n = 2'd1;
			default: n = 2'd2;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

### src/obd_if.sv
// ----------------------------------------------------------------------------
// obd_in_if / obd_out_if
// Valid/ready channels for responses and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none
interface obd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] service_mode;
	logic [7:0] pid_code;
	logic [7:0] first_data_byte;
	logic [7:0] second_data_byte;
	logic [2:0] data_count;
	modport source(output valid, service_mode, pid_code, first_data_byte,
		second_data_byte, data_count, input ready);
	modport sink(input valid, service_mode, pid_code, first_data_byte,
		second_data_byte, data_count, output ready);
endinterface

interface obd_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         decode_status;
	logic signed [33:0] scaled_value;
	logic [7:0]         pid_echo;
	modport source(output valid, decode_status, scaled_value, pid_echo, input ready);
	modport sink(input valid, decode_status, scaled_value, pid_echo, output ready);
endinterface
`default_nettype wire

### src/obd_front.sv
// ----------------------------------------------------------------------------
// obd_front
// Accepts responses, classifies them and queues them for the back part.
// ----------------------------------------------------------------------------
`default_nettype none
module obd_front #(
	parameter int unsigned DEPTH = obd_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	obd_in_if.sink           rsp,
	output obd_pkg::cls_t    q_data,
	output logic             q_valid,
	input  wire logic        q_pop
);
	import obd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cls_t           mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	cls_t           cls;
	rule_t          rule;
	logic           push;

	// Classification
	always_comb begin
		rule = (rsp.service_mode == MODE_CURRENT) ? rule_of(rsp.pid_code) : R_NONE;
		cls.rule = rule;
		cls.a    = rsp.first_data_byte;
		cls.w    = {rsp.first_data_byte, rsp.second_data_byte};
		cls.pid  = rsp.pid_code;
		if (rule == R_NONE) begin
			cls.status = ST_UNKN;
		end else if (rsp.data_count < {1'b0, bytes_needed(rule)}) begin
			cls.status = ST_SHORT;
		end else begin
			cls.status = ST_OK;
		end
	end

	assign rsp.ready = (cnt_q < (AW+1)'(DEPTH)) || q_pop;
	assign push      = rsp.valid && rsp.ready;
	assign q_valid   = (cnt_q != '0);
	assign q_data    = mem_q[rd_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == (AW+1)'(DEPTH) && !q_pop) |-> !rsp.ready) else $error("ready while full");
endmodule
`default_nettype wire

### src/obd_back.sv
// ----------------------------------------------------------------------------
// obd_back
// Applies the scaling rule in two stages and holds the result for the sink.
// ----------------------------------------------------------------------------
`default_nettype none
module obd_back (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  obd_pkg::cls_t q_data,
	input  wire logic     q_valid,
	output logic          q_pop,
	obd_out_if.source     res
);
	import obd_pkg::*;

	// Stage 1: numerator magnitude and sign
	logic               v_s1;
	rule_t              rule_s1;
	status_t            st_s1;
	logic [7:0]         pid_s1;
	logic [34:0]        mag_s1;
	logic               neg_s1;
	logic signed [34:0] num;
	logic               adv1, adv2;
	logic signed [18:0] s;
	logic signed [34:0] av, wv;

	// Stage 2 / output register
	logic               v_s2;
	status_t            st_s2;
	logic [7:0]         pid_s2;
	logic signed [33:0] val_s2;
	logic [34:0]        q;
	logic signed [34:0] rounded;
	logic signed [34:0] val;

	// Constant dividers by reciprocal multiplication
	logic [34:0]        t255, t200, t20, tmph;
	logic [25:0]        y255;
	logic [20:0]        y25;
	logic [15:0]        y5;
	logic [24:0]        ympg;
	logic [52:0]        p255;
	logic [42:0]        p25;
	logic [31:0]        p5;
	logic [50:0]        pmph;

	assign adv2  = !v_s2 || res.ready;
	assign adv1  = !v_s1 || adv2;
	assign q_pop = q_valid && adv1;

	// Exact numerator per rule; signed for the offset-style rules
	always_comb begin
		av = 35'(q_data.a);
		wv = 35'(q_data.w);
		s  = q_data.w[15] ? 19'(signed'({3'b111, q_data.w})) : 19'(q_data.w);
		case (q_data.rule)
			R_PCT:     num = av * 35'sd1000;
			R_CTR:     num = (av - 35'sd128) * 35'sd1000;
			R_RPM:     num = wv * 35'sd5;
			R_RAILVAC: num = wv * 35'sd79;
			R_EVAP:    num = 35'(s) * 35'sd5;
			R_CAT:     num = wv - 35'sd400;
			R_EQUIV:   num = wv * 35'sd1000;
			R_INJ:     num = wv * 35'sd100 - 35'sd2688000;
			R_MPH:     num = av * 35'sd6213710;
			R_ABSLOAD: num = wv * 35'sd1000;
			default:   num = wv;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rule_s1 <= q_data.rule;
			st_s1   <= q_data.status;
			pid_s1  <= q_data.pid;
			if (q_data.rule == R_NONE) begin
				mag_s1 <= '0;
				neg_s1 <= 1'b0;
			end else begin
				mag_s1 <= num[34] ? 35'(-num) : 35'(num);
				neg_s1 <= num[34];
			end
		end
	end

	// Rounded quotients: halve or shift by the power-of-two factor, then
	// multiply by the scaled reciprocal of the odd factor
	always_comb begin
		t255 = (mag_s1 << 1) + 35'd255;
		y255 = t255[26:1];
		p255 = y255 * 27'd67372037;
		t200 = (mag_s1 << 1) + 35'd100;
		y25  = t200[23:3];
		p25  = y25 * 22'd2684355;
		t20  = (mag_s1 << 1) + 35'd10;
		y5   = t20[17:2];
		p5   = y5 * 16'd52429;
		tmph = (mag_s1 << 1) + 35'd1000000;
		ympg = tmph[31:7];
		pmph = ympg * 26'd35184373;
	end

	// Rounded division by rule constant, then final scale
	always_comb begin
		case (rule_s1)
			R_PCT, R_ABSLOAD: q = 35'(p255[52:34]);
			R_CTR:            q = ((mag_s1 << 1) + 35'd128) >> 8;
			R_RPM, R_EVAP,
			R_ABSEVAP:        q = ((mag_s1 << 1) + 35'd2) >> 2;
			R_RAILVAC:        q = 35'(p25[42:26]);
			R_CAT, R_VOLT:    q = 35'(p5[31:18]);
			R_EQUIV:          q = ((mag_s1 << 1) + 35'd32768) >> 16;
			R_INJ:            q = ((mag_s1 << 1) + 35'd128) >> 8;
			R_MPH:            q = 35'(pmph[50:39]);
			default:          q = mag_s1;
		endcase
		rounded = neg_s1 ? -signed'(q) : signed'(q);
		case (rule_s1)
			R_SIMPLE, R_KPA:  val = 35'(mag_s1[15:8]) * 35'sd10000;
			R_U16:            val = mag_s1 * 35'sd10000;
			R_OFF40:          val = (35'(mag_s1[15:8]) - 35'sd40) * 35'sd10000;
			R_PCT, R_CTR, R_RPM, R_RAILVAC, R_EVAP, R_MPH, R_ABSLOAD:
				val = rounded * 35'sd1000;
			R_FPRESS:         val = 35'(mag_s1[15:8]) * 35'sd30000;
			R_TIMING:         val = (35'sd5 * 35'(mag_s1[15:8]) - 35'sd640) * 35'sd1000;
			R_MAF:            val = mag_s1 * 35'sd100;
			R_O2V:            val = 35'(mag_s1[15:8]) * 35'sd50;
			R_RAILW10:        val = mag_s1 * 35'sd100000;
			R_CAT:            val = rounded * 35'sd10000;
			R_VOLT, R_INJ, R_ABSEVAP: val = rounded * 35'sd100;
			R_EQUIV:          val = rounded * 35'sd10;
			R_FRATE:          val = mag_s1 * 35'sd500;
			R_MAXMAF:         val = 35'(mag_s1[15:8]) * 35'sd100000;
			default:          val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			st_s2  <= st_s1;
			pid_s2 <= pid_s1;
			val_s2 <= (st_s1 == ST_OK) ? val[33:0] : '0;
		end
	end

	assign res.valid         = v_s2;
	assign res.decode_status = st_s2;
	assign res.pid_echo      = pid_s2;
	assign res.scaled_value  = val_s2;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !res.ready) |=> v_s2) else $error("result dropped");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && st_s2 != ST_OK) |-> val_s2 == '0) else $error("nonzero value on error");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> st_s2 != 2'd3) else $error("bad status");
endmodule
`default_nettype wire

### src/obd_pid_value_decoder_unit.sv
// ----------------------------------------------------------------------------
// obd_pid_value_decoder_unit
// OBD-II mode-1 PID decoder: classify, queue, scale and round to x10000.
// ----------------------------------------------------------------------------
// channel | dir | fields
// rsp     | in  | service_mode, pid_code, first_data_byte, second_data_byte, data_count
// res     | out | decode_status, scaled_value, pid_echo
//
// One item per cycle while the sink is ready; items pass the queue, numerator
// stage and rounding stage with output register. Reset clears queue and stage
// valids. A stalled result sink fills the two-entry queue before input ready drops.
`default_nettype none
module obd_pid_value_decoder_unit #(
	parameter int unsigned DEPTH = obd_pkg::QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	obd_in_if.sink   rsp,
	obd_out_if.source res
);
	import obd_pkg::*;

	cls_t q_data;
	logic q_valid, q_pop;

	obd_front #(.DEPTH(DEPTH)) u_front (
		.clk, .arst_n, .rsp, .q_data, .q_valid, .q_pop
	);

	obd_back u_back (
		.clk, .arst_n, .q_data, .q_valid, .q_pop, .res
	);
endmodule
`default_nettype wire

### sim/obd_pid_value_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// obd_pid_value_decoder_unit_tb
// Drives OBD-II responses into the PID value decoder and checks every decoded
// result against an independent predictor of lookup, byte need and rounding.
// ----------------------------------------------------------------------------
`default_nettype none
module obd_pid_value_decoder_unit_tb;
	import obd_pkg::*;

	typedef struct packed {
		status_t            status;
		logic signed [33:0] value;
		logic [7:0]         pid;
	} decoded_t;

	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   snk_stall_pct;
	int   fail_count;
	int   quiet_cycles;
	decoded_t expected_q[$];

	obd_in_if  rsp();
	obd_out_if res();

	obd_pid_value_decoder_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rsp    (rsp),
		.res    (res)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Rounded num/den, half away from zero
	function automatic longint round_div(input longint num, input longint den);
		if (num >= 0)
			return (2 * num + den) / (2 * den);
		return -((2 * (-num) + den) / (2 * den));
	endfunction

	// Scaling rule lookup, written out independently of the package table
	function automatic rule_t pid_rule(input logic [7:0] pid);
		case (pid)
			8'h05, 8'h0F, 8'h46, 8'h5C: return R_OFF40;
			8'h04, 8'h11, 8'h2C, 8'h2E, 8'h2F, 8'h45, 8'h47, 8'h49, 8'h4A,
			8'h4B, 8'h4C, 8'h4F, 8'h52, 8'h5A, 8'h5B: return R_PCT;
			8'h06, 8'h07, 8'h08, 8'h09, 8'h2D, 8'h56, 8'h57, 8'h58: return R_CTR;
			8'h42: return R_VOLT;
			8'h0E: return R_TIMING;
			8'h10: return R_MAF;
			8'h0D: return R_MPH;
			8'h0C: return R_RPM;
			8'h44: return R_EQUIV;
			8'h0B, 8'h33: return R_KPA;
			8'h14, 8'h15, 8'h16, 8'h17: return R_O2V;
			8'h0A: return R_FPRESS;
			8'h1F, 8'h21, 8'h31, 8'h4D, 8'h4E: return R_U16;
			8'h22: return R_RAILVAC;
			8'h23, 8'h59: return R_RAILW10;
			8'h3C, 8'h3D, 8'h3E, 8'h3F: return R_CAT;
			8'h32, 8'h55: return R_EVAP;
			8'h30, 8'h51: return R_SIMPLE;
			8'h43: return R_ABSLOAD;
			8'h50: return R_MAXMAF;
			8'h54: return R_ABSEVAP;
			8'h5D: return R_INJ;
			8'h5E: return R_FRATE;
			default: return R_NONE;
		endcase
	endfunction

	// Expected result of one response
	function automatic decoded_t decode_response(input logic [7:0] mode,
		input logic [7:0] pid, input logic [7:0] a_byte, input logic [7:0] b_byte,
		input logic [2:0] count);
		decoded_t d;
		rule_t    r;
		longint   a;
		longint   w;
		longint   v;
		int       need;
		a = longint'(a_byte);
		w = a * 256 + longint'(b_byte);
		v = 0;
		r = (mode == MODE_CURRENT) ? pid_rule(pid) : R_NONE;
		case (r)
			R_SIMPLE, R_OFF40, R_PCT, R_CTR, R_KPA, R_FPRESS, R_TIMING,
			R_MPH, R_MAXMAF: need = 1;
			default: need = 2;
		endcase
		d.pid = pid;
		if (r == R_NONE) begin
			d.status = ST_UNKN;
		end else if (count < need) begin
			d.status = ST_SHORT;
		end else begin
			d.status = ST_OK;
			case (r)
				R_SIMPLE, R_KPA, R_U16: v = (r == R_U16) ? w * 10000 : a * 10000;
				R_OFF40:   v = (a - 40) * 10000;
				R_PCT:     v = round_div(a * 1000, 255) * 1000;
				R_CTR:     v = round_div((a - 128) * 1000, 128) * 1000;
				R_RPM:     v = round_div(w * 5, 2) * 1000;
				R_FPRESS:  v = a * 30000;
				R_TIMING:  v = (5 * a - 640) * 1000;
				R_MAF:     v = w * 100;
				R_O2V:     v = a * 50;
				R_RAILVAC: v = round_div(w * 79, 100) * 1000;
				R_RAILW10: v = w * 100000;
				R_EVAP:    v = round_div(((w > 32767) ? w - 65536 : w) * 5, 2) * 1000;
				R_CAT:     v = round_div(w - 400, 10) * 10000;
				R_VOLT:    v = round_div(w, 10) * 100;
				R_EQUIV:   v = round_div(w * 1000, 32768) * 10;
				R_FRATE:   v = w * 500;
				R_INJ:     v = round_div(w * 100 - 2688000, 128) * 100;
				R_ABSEVAP: v = round_div(w, 2) * 100;
				R_MPH:     v = round_div(a * 6213710, 1000000) * 1000;
				R_ABSLOAD: v = round_div(w * 1000, 255) * 1000;
				R_MAXMAF:  v = a * 100000;
				default:   v = 0;
			endcase
		end
		d.value = v[33:0];
		return d;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Send one response; valid held high across back-to-back items
	task automatic send_response(input logic [7:0] mode, input logic [7:0] pid,
		input logic [7:0] a_byte, input logic [7:0] b_byte, input logic [2:0] count);
		while ($urandom_range(99) < src_idle_pct) begin
			rsp.valid <= 1'b0;
			@(posedge clk);
		end
		rsp.valid            <= 1'b1;
		rsp.service_mode     <= mode;
		rsp.pid_code         <= pid;
		rsp.first_data_byte  <= a_byte;
		rsp.second_data_byte <= b_byte;
		rsp.data_count       <= count;
		expected_q.push_back(decode_response(mode, pid, a_byte, b_byte, count));
		@(posedge clk);
		while (!rsp.ready) @(posedge clk);
	endtask

	// Result sink ready and check of each accepted result
	always @(posedge clk) begin
		decoded_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result, pid", res.pid_echo, -1);
				end else begin
					want = expected_q.pop_front();
					if (res.decode_status !== want.status)
						report_mismatch("decode_status", res.decode_status, want.status);
					if (res.scaled_value !== want.value)
						report_mismatch("scaled_value", res.scaled_value, want.value);
					if (res.pid_echo !== want.pid)
						report_mismatch("pid_echo", res.pid_echo, want.pid);
				end
			end
			res.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((rsp.valid && rsp.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Extremes of A and B, short counts and unknown modes, then every table PID with random A and B
	task automatic test_directed();
		send_response(MODE_CURRENT, 8'h05, 8'h00, 8'h00, 3'd1);
		send_response(MODE_CURRENT, 8'h04, 8'hFF, 8'hFF, 3'd7);
		send_response(MODE_CURRENT, 8'h06, 8'h00, 8'h00, 3'd1);
		send_response(MODE_CURRENT, 8'h0C, 8'hFF, 8'hFF, 3'd2);
		send_response(MODE_CURRENT, 8'h32, 8'h80, 8'h00, 3'd2);
		send_response(MODE_CURRENT, 8'h32, 8'h7F, 8'hFF, 3'd2);
		send_response(MODE_CURRENT, 8'h3C, 8'h00, 8'h00, 3'd2);
		send_response(MODE_CURRENT, 8'h5D, 8'h00, 8'h00, 3'd4);
		send_response(MODE_CURRENT, 8'h23, 8'hFF, 8'hFF, 3'd2);
		send_response(MODE_CURRENT, 8'h0E, 8'h00, 8'h00, 3'd1);
		send_response(MODE_CURRENT, 8'h0D, 8'hFF, 8'h00, 3'd1);
		// O2 voltage needs two bytes though only A is used
		send_response(MODE_CURRENT, 8'h14, 8'hC8, 8'h00, 3'd1);
		send_response(MODE_CURRENT, 8'h14, 8'hC8, 8'h00, 3'd2);
		send_response(MODE_CURRENT, 8'h42, 8'h30, 8'h39, 3'd0);
		send_response(MODE_CURRENT, 8'h0C, 8'h10, 8'h00, 3'd1);
		send_response(8'h00, 8'h0C, 8'h10, 8'h00, 3'd2);
		send_response(8'hFF, 8'h05, 8'h10, 8'h00, 3'd2);
		send_response(MODE_CURRENT, 8'hFF, 8'h10, 8'h00, 3'd2);
		send_response(MODE_CURRENT, 8'h00, 8'h10, 8'h00, 3'd2);
		send_response(MODE_CURRENT, 8'h44, 8'hFF, 8'hFF, 3'd5);
		send_response(MODE_CURRENT, 8'h50, 8'hFF, 8'h00, 3'd6);
		for (int p = 0; p < 256; p++)
			if (pid_rule(8'(p)) != R_NONE)
				send_response(MODE_CURRENT, 8'(p), 8'($urandom_range(255)),
					8'($urandom_range(255)), 3'd2);
	endtask

	// Random responses: mostly known PIDs with enough bytes, the rest noise
	task automatic test_random(input int n_items);
		logic [7:0] pid;
		logic [7:0] mode;
		for (int i = 0; i < n_items; i++) begin
			do pid = 8'($urandom_range(8'h04, 8'h5E)); while ($urandom_range(9) < 8 &&
				pid_rule(pid) == R_NONE);
			mode = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : MODE_CURRENT;
			if ($urandom_range(19) == 0) pid = 8'($urandom_range(255));
			send_response(mode, pid, 8'($urandom_range(255)), 8'($urandom_range(255)),
				($urandom_range(9) < 8) ? 3'($urandom_range(2, 7)) : 3'($urandom_range(1)));
		end
	endtask

	task automatic test_idling();
		int idle_set[4] = '{0, 66, 0, 14};
		int stall_set[4] = '{0, 0, 66, 14};
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct  = idle_set[ph];
			snk_stall_pct = stall_set[ph];
			test_random(240);
		end
		src_idle_pct  = 0;
		snk_stall_pct = 0;
	endtask

	// Stimulus sequence
	initial begin
		fail_count           = 0;
		quiet_cycles         = 0;
		src_idle_pct         = 0;
		snk_stall_pct        = 0;
		arst_n               = 1'b0;
		rsp.valid            = 1'b0;
		rsp.service_mode     = '0;
		rsp.pid_code         = '0;
		rsp.first_data_byte  = '0;
		rsp.second_data_byte = '0;
		rsp.data_count       = '0;
		res.ready            = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_idling();
		rsp.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
